FILE: hdl/serial_frame_magic_demux_macros.svh
// assertion macros for the serial frame demultiplexer
`ifndef SERIAL_FRAME_MAGIC_DEMUX_MACROS_SVH
`define SERIAL_FRAME_MAGIC_DEMUX_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SFMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SFMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sfmd_pkg.sv
// shared types, constants and helpers of the serial frame demultiplexer
`default_nettype none

package sfmd_pkg;

    // fixed widths
    localparam int unsigned WORD_W      = 48;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned HELD_W      = 3;
    localparam int unsigned BODY_W      = 9;
    localparam int unsigned HEADER_LEN  = 3;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // reset magic word, ascii IMPROV
    localparam logic [WORD_W-1:0] MAGIC_RESET = 48'h494D50524F56;

    // operation codes
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // destinations
    localparam logic DEST_CONSOLE = 1'b0;
    localparam logic DEST_FRAME   = 1'b1;

    // input request
    typedef struct packed {
        logic       operation;
        logic [7:0] in_byte;
    } t_in_req;

    // output result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_dest;
        logic       last;
    } t_out_res;

    // queued command: some magic bytes, then an optional tail byte
    typedef struct packed {
        logic [CNT_W-1:0] magic_cnt;
        logic             magic_dest;
        logic             tail_valid;
        logic [7:0]       tail_byte;
        logic             tail_dest;
    } t_cmd;

    // magic byte k of the word, zero when out of range
    function automatic logic [7:0] f_magic_byte(input logic [WORD_W-1:0] word,
                                                input logic [CNT_W-1:0]  ml,
                                                input logic [2:0]        k);
        logic [7:0] res;
        int         pos;
        res = '0;
        pos = 0;
        if ({1'b0, k} < ml) begin
            pos = 8 * (int'(ml) - 1 - int'(k));
            if (pos < int'(WORD_W)) begin
                res = word[pos +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/serial_frame_magic_demux.sv
// top level of the serial frame demultiplexer
//
// Usage: requests enter on i_in_valid / i_in_req / o_in_stall; a request is
// either a received byte or a resync. Results leave on o_out_valid /
// o_out_res / i_out_stall, each with its byte, its destination (console or
// frame path) and a last flag on the final result of a request.
// The magic word is written over i_cfg_valid / i_cfg_data; o_cfg_ready is
// always high, and writes belong to idle periods only.
// When the queue is empty and the output register is free, the first result
// of a request passes through the command queue and then the output register.
// Throughput: one result per cycle from the output register while i_out_stall
// is low. A request causes one result for most bytes and up to MAGIC_LEN for
// a completed magic or a replayed prefix; held bytes and resync cause none.
// The classifier runs ahead of the emitter through a two-entry command
// queue; o_in_stall rises only when that queue is full.
// Reset clears the phase to idle, empties the queue and loads the magic
// word with ascii IMPROV. While i_out_stall is high the pending result holds
// and the queue fills, then the input side stalls.
`default_nettype none
`include "serial_frame_magic_demux_macros.svh"

module serial_frame_magic_demux
    import sfmd_pkg::*;
#(
    parameter int unsigned MAGIC_LEN = 6
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  t_in_req           i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_res          o_out_res,
    input  wire               i_out_stall,
    input  wire               i_cfg_valid,
    input  wire  [WORD_W-1:0] i_cfg_data,
    output logic              o_cfg_ready
);

    logic [WORD_W-1:0] r_magic_word;
    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    t_cmd              w_push_cmd;
    t_cmd              w_head_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;

    // magic word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word <= MAGIC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_magic_word <= i_cfg_data;
        end
    end

    // classifier
    sfmd_front #(
        .MAGIC_LEN (MAGIC_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_magic_word (r_magic_word),
        .i_in_valid   (i_in_valid),
        .i_in_req     (i_in_req),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    // command queue
    sfmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    // emitter
    sfmd_back #(
        .MAGIC_LEN (MAGIC_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_magic_word (r_magic_word),
        .i_empty      (w_empty),
        .i_cmd        (w_head_cmd),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out_res    (o_out_res),
        .i_out_stall  (i_out_stall)
    );

    // checks
    `SFMD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
    `SFMD_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_empty, "pop from empty queue")
    `SFMD_ASSERT_NOW(a_resync_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_req.operation == OP_RESYNC, !w_push, "resync queued a command")
    `SFMD_ASSERT_NEXT(a_out_from_queue, i_clk, i_rst_n, !o_out_valid, !o_out_valid || $past(!w_empty), "result without queued command")

endmodule

`default_nettype wire

FILE: hdl/sfmd_queue.sv
// two-entry command queue between the classifier and the emitter
`default_nettype none

module sfmd_queue
    import sfmd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  wire  i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfmd_front.sv
// classifier: tracks frame phase and turns each request into a command
`default_nettype none

module sfmd_front
    import sfmd_pkg::*;
#(
    parameter int unsigned MAGIC_LEN = 6
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [WORD_W-1:0] i_magic_word,
    input  wire               i_in_valid,
    input  t_in_req           i_in_req,
    input  wire               i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam logic [CNT_W-1:0] ML = CNT_W'(MAGIC_LEN);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_MAGIC  = 4'b0010,
        PH_HEADER = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [HELD_W-1:0] r_held, n_held;
    logic [BODY_W-1:0] r_body, n_body;

    logic             w_accept;
    logic [7:0]       w_byte;
    logic [CNT_W-1:0] w_held_ext;
    logic [CNT_W-1:0] w_held_inc;
    logic [CNT_W-1:0] w_prefix;
    logic [HELD_W-1:0] w_hdr_inc;
    t_cmd             w_cmd;
    logic             w_push;

    assign w_accept   = i_in_valid && !i_full;
    assign w_byte     = i_in_req.in_byte;
    assign w_held_ext = {1'b0, r_held};
    assign w_held_inc = w_held_ext + CNT_W'(1);
    assign w_prefix   = (w_held_ext < ML - CNT_W'(1)) ? w_held_ext : ML - CNT_W'(1);
    assign w_hdr_inc  = r_held + HELD_W'(1);

    // next state and command
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_body  = r_body;
        w_push  = 1'b0;
        w_cmd   = '{magic_cnt: '0, magic_dest: DEST_CONSOLE, tail_valid: 1'b1,
                    tail_byte: w_byte, tail_dest: DEST_CONSOLE};
        if (w_accept) begin
            if (i_in_req.operation == OP_RESYNC) begin
                n_phase = PH_IDLE;
                n_held  = '0;
                n_body  = '0;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (w_byte == f_magic_byte(i_magic_word, ML, 3'd0)) begin
                            if (ML <= CNT_W'(1)) begin
                                w_push           = 1'b1;
                                w_cmd.magic_cnt  = ML;
                                w_cmd.magic_dest = DEST_FRAME;
                                w_cmd.tail_valid = 1'b0;
                                n_phase          = PH_HEADER;
                                n_held           = '0;
                            end else begin
                                n_phase = PH_MAGIC;
                                n_held  = HELD_W'(1);
                            end
                        end else begin
                            w_push = 1'b1;
                        end
                    end
                    PH_MAGIC: begin
                        if (w_held_ext < ML &&
                            w_byte == f_magic_byte(i_magic_word, ML, r_held)) begin
                            if (w_held_inc >= ML) begin
                                w_push           = 1'b1;
                                w_cmd.magic_cnt  = ML;
                                w_cmd.magic_dest = DEST_FRAME;
                                w_cmd.tail_valid = 1'b0;
                                n_phase          = PH_HEADER;
                                n_held           = '0;
                            end else begin
                                n_held = w_held_inc[HELD_W-1:0];
                            end
                        end else begin
                            // mismatch: replay held prefix, then this byte
                            w_push          = 1'b1;
                            w_cmd.magic_cnt = w_prefix;
                            n_phase         = PH_IDLE;
                            n_held          = '0;
                        end
                    end
                    PH_HEADER: begin
                        w_push          = 1'b1;
                        w_cmd.tail_dest = DEST_FRAME;
                        if (w_hdr_inc >= HELD_W'(HEADER_LEN)) begin
                            n_body  = {1'b0, w_byte} + BODY_W'(1);
                            n_phase = PH_BODY;
                            n_held  = '0;
                        end else begin
                            n_held = w_hdr_inc;
                        end
                    end
                    PH_BODY: begin
                        w_push          = 1'b1;
                        w_cmd.tail_dest = DEST_FRAME;
                        if (r_body > BODY_W'(1)) begin
                            n_body = r_body - BODY_W'(1);
                        end else begin
                            n_body  = '0;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_held  = '0;
                        n_body  = '0;
                    end
                endcase
            end
        end
    end

    assign o_push = w_push;
    assign o_cmd  = w_cmd;

    // phase registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_body  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_body  <= n_body;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfmd_back.sv
// emitter: expands queued commands into one result per cycle while the output is not stalled
`default_nettype none

module sfmd_back
    import sfmd_pkg::*;
#(
    parameter int unsigned MAGIC_LEN = 6
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [WORD_W-1:0] i_magic_word,
    input  wire               i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    output t_out_res          o_out_res,
    input  wire               i_out_stall
);

    localparam logic [CNT_W-1:0] ML = CNT_W'(MAGIC_LEN);

    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_out_valid;
    t_out_res         r_out_res;

    logic             w_step;
    logic             w_in_magic;
    logic             w_magic_last;
    logic             w_final;
    t_out_res         w_res;

    assign w_step       = !i_empty && (!r_out_valid || !i_out_stall);
    assign w_in_magic   = r_idx < i_cmd.magic_cnt;
    assign w_magic_last = (r_idx + CNT_W'(1)) == i_cmd.magic_cnt;

    // select the next result of the head command
    always_comb begin
        if (w_in_magic) begin
            w_res.out_byte = f_magic_byte(i_magic_word, ML, r_idx[2:0]);
            w_res.out_dest = i_cmd.magic_dest;
            w_final        = w_magic_last && !i_cmd.tail_valid;
        end else begin
            w_res.out_byte = i_cmd.tail_byte;
            w_res.out_dest = i_cmd.tail_dest;
            w_final        = 1'b1;
        end
        w_res.last = w_final;
        n_idx      = r_idx;
        if (w_step) begin
            n_idx = w_final ? '0 : r_idx + CNT_W'(1);
        end
    end

    assign o_pop = w_step && w_final;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

`default_nettype wire

FILE: dv/serial_frame_magic_demux_checker.sv
// result predictor and comparator for the serial frame demultiplexer testbench
`default_nettype none

module serial_frame_magic_demux_checker
    import sfmd_pkg::*;
#(
    parameter int unsigned MAGIC_LEN = 6
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  t_in_req           i_in_req,
    input  wire               i_in_stall,
    input  wire               i_out_valid,
    input  t_out_res          i_out_res,
    input  wire               i_out_stall,
    input  wire               i_cfg_valid,
    input  wire  [WORD_W-1:0] i_cfg_data,
    input  wire               i_cfg_ready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count
);

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MAGIC,
        FR_HEADER,
        FR_BODY
    } t_frame_phase;

    // shadow of the routing state and the magic register
    t_frame_phase      phase;
    logic [HELD_W-1:0] held;
    logic [BODY_W-1:0] body_left;
    logic [WORD_W-1:0] magic;

    // expected results, oldest first, and the ones of the request in progress
    t_out_res expected_q[$];
    t_out_res staged[$];
    t_out_res want;
    int       fails;
    int       results;

    // magic byte k, first byte in the top bits, zero when out of range
    function automatic logic [7:0] magic_at(input int k);
        int pos;
        if (k >= int'(MAGIC_LEN)) begin
            return 8'h00;
        end
        pos = 8 * (int'(MAGIC_LEN) - 1 - k);
        if (pos >= int'(WORD_W)) begin
            return 8'h00;
        end
        return magic[pos +: 8];
    endfunction

    function automatic void route(input logic [7:0] b, input logic dest);
        staged.push_back({b, dest, 1'b0});
    endfunction

    // work out the results of one accepted request and queue them
    function automatic void predict_request(input t_in_req req);
        logic [7:0] b;
        t_out_res   r;
        bit         check_done;
        b = req.in_byte;
        check_done = 1'b0;
        staged.delete();
        if (req.operation == OP_RESYNC) begin
            phase     = FR_IDLE;
            held      = '0;
            body_left = '0;
        end else begin
            case (phase)
                FR_IDLE: begin
                    if (b == magic_at(0)) begin
                        held       = 1;
                        phase      = FR_MAGIC;
                        check_done = 1'b1;
                    end else begin
                        route(b, DEST_CONSOLE);
                    end
                end
                FR_MAGIC: begin
                    if (int'(held) < int'(MAGIC_LEN) && b == magic_at(int'(held))) begin
                        held       = held + 1'b1;
                        check_done = 1'b1;
                    end else begin
                        // replay the held prefix, then the byte itself, all to the console
                        for (int k = 0; k < int'(held) && k < int'(MAGIC_LEN) - 1; k++) begin
                            route(magic_at(k), DEST_CONSOLE);
                        end
                        route(b, DEST_CONSOLE);
                        held  = '0;
                        phase = FR_IDLE;
                    end
                end
                FR_HEADER: begin
                    route(b, DEST_FRAME);
                    held = held + 1'b1;
                    if (int'(held) >= int'(HEADER_LEN)) begin
                        // third header byte is the payload length, checksum follows
                        body_left = {1'b0, b} + 1'b1;
                        phase     = FR_BODY;
                        held      = '0;
                    end
                end
                default: begin
                    route(b, DEST_FRAME);
                    if (body_left != 0) begin
                        body_left = body_left - 1'b1;
                    end
                    if (body_left == 0) begin
                        phase = FR_IDLE;
                    end
                end
            endcase
            // whole magic seen: release it on the frame path
            if (check_done && int'(held) >= int'(MAGIC_LEN)) begin
                for (int k = 0; k < int'(MAGIC_LEN); k++) begin
                    route(magic_at(k), DEST_FRAME);
                end
                phase = FR_HEADER;
                held  = '0;
            end
        end
        for (int i = 0; i < staged.size(); i++) begin
            r      = staged[i];
            r.last = (i == staged.size() - 1);
            expected_q.push_back(r);
        end
    endfunction

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = FR_IDLE;
            held      = '0;
            body_left = '0;
            magic     = MAGIC_RESET;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: out_byte %02h out_dest %0b last %0b",
                           i_out_res.out_byte, i_out_res.out_dest, i_out_res.last);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_res.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, i_out_res.out_byte);
                        fails++;
                    end
                    if (i_out_res.out_dest !== want.out_dest) begin
                        $error("out_dest: expected %0b, got %0b",
                               want.out_dest, i_out_res.out_dest);
                        fails++;
                    end
                    if (i_out_res.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_out_res.last);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                magic = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_in_req);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= expected_q.size();
        o_result_count <= results;
    end

endmodule

`default_nettype wire

FILE: dv/serial_frame_magic_demux_tb.sv
// stimulus, handshake timing and verdict for the serial frame demultiplexer
`default_nettype none

module serial_frame_magic_demux_tb;
    import sfmd_pkg::*;

    localparam int unsigned MAGIC_N = 6;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD        = 400;
    localparam int SETTLE_CYCLES    = 12;
    localparam int RUN_ITEMS        = 20;
    localparam int LONG_BODY_SEEN   = 24;

    // block inputs, known from time zero
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_req           in_req    = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [WORD_W-1:0] cfg_data  = '0;

    logic     in_stall;
    logic     out_valid;
    t_out_res out_res;
    logic     cfg_ready;

    int fail_count;
    int pending;
    int result_count;

    // stimulus side view of the magic word, used to build frames
    logic [WORD_W-1:0] cur_magic = MAGIC_RESET;
    int                sent        = 0;
    int                settings    = 1;
    int                idle_cycles = 0;
    bit                in_no_gap   = 1'b0;
    bit                out_no_gap  = 1'b0;
    bit                long_hold_req = 1'b0;

    always #5 clk = ~clk;

    serial_frame_magic_demux #(
        .MAGIC_LEN(MAGIC_N)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_req   (in_req),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_res  (out_res),
        .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid),
        .i_cfg_data (cfg_data),
        .o_cfg_ready(cfg_ready)
    );

    serial_frame_magic_demux_checker #(
        .MAGIC_LEN(MAGIC_N)
    ) i_frame_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_req      (in_req),
        .i_in_stall    (in_stall),
        .i_out_valid   (out_valid),
        .i_out_res     (out_res),
        .i_out_stall   (out_stall),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_data    (cfg_data),
        .i_cfg_ready   (cfg_ready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(input bit no_gap);
        return no_gap ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] magic_byte_of(input int k);
        return cur_magic[8 * (int'(MAGIC_N) - 1 - k) +: 8];
    endfunction

    // offer one request and hold it until it is taken
    task automatic send_req(input logic op, input logic [7:0] b);
        int gap;
        gap = draw_gap(in_no_gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= {op, b};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(OP_BYTE, b);
    endtask

    // full frame: magic, two header bytes, length, payload and checksum;
    // a cut position at or above zero swaps that byte for a resync and stops
    task automatic send_frame(input int len, input int cut);
        logic [7:0] seq[$];
        for (int k = 0; k < int'(MAGIC_N); k++) begin
            seq.push_back(magic_byte_of(k));
        end
        seq.push_back(8'($urandom_range(0, 255)));
        seq.push_back(8'($urandom_range(0, 255)));
        seq.push_back(8'(len));
        for (int i = 0; i <= len; i++) begin
            seq.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < seq.size(); i++) begin
            if (i == cut) begin
                send_req(OP_RESYNC, 8'($urandom_range(0, 255)));
                break;
            end
            send_byte(seq[i]);
        end
    endtask

    // part of the magic, then a byte that breaks it
    task automatic send_broken_prefix();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, MAGIC_N - 1);
        for (int k = 0; k < n; k++) begin
            send_byte(magic_byte_of(k));
        end
        b = 8'($urandom_range(0, 255));
        if (b == magic_byte_of(n)) begin
            b = b ^ 8'h01;
        end
        send_byte(b);
    endtask

    // mostly well formed frames, with aborted frames, broken magic and noise
    task automatic run_mixed_traffic(input int items, input bit long_frame, input bit squeeze);
        int         target;
        int         sel;
        int         len;
        int         n;
        bit         hit;
        logic [7:0] b;
        in_no_gap  = ($urandom_range(0, 3) == 0);
        out_no_gap = ($urandom_range(0, 3) == 0);
        if (squeeze) begin
            in_no_gap     = 1'b1;
            long_hold_req = 1'b1;
        end
        target = sent + items;
        if (long_frame) begin
            // largest length byte, cut well into the body
            send_frame(255, int'(MAGIC_N) + 3 + LONG_BODY_SEEN);
        end
        while (sent < target) begin
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                send_frame(len, -1);
            end else if (sel == 6) begin
                len = $urandom_range(0, 6);
                send_frame(len, $urandom_range(0, MAGIC_N + 3 + len));
            end else if (sel == 7) begin
                send_broken_prefix();
            end else if (sel == 8) begin
                // noise; a byte that may start the magic is cleaned up by a resync
                n   = $urandom_range(1, 4);
                hit = 1'b0;
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == magic_byte_of(0)) begin
                        hit = 1'b1;
                    end
                    send_byte(b);
                end
                if (hit) begin
                    send_req(OP_RESYNC, 8'($urandom_range(0, 255)));
                end
            end else begin
                send_req(OP_RESYNC, 8'($urandom_range(0, 255)));
            end
        end
        // leave the block idle and drained
        send_req(OP_RESYNC, 8'($urandom_range(0, 255)));
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_magic(input logic [WORD_W-1:0] w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_magic = w;
        settings++;
    endtask

    // result side: per result stall, plus one long hold on request
    initial begin
        int n;
        wait (rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            n = draw_gap(out_no_gap);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // request side: directed cases, then mixed traffic under several magic words
    initial begin
        logic [63:0] r64;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // console extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        // complete frame with reset magic, zero length, extreme header bytes
        for (int k = 0; k < int'(MAGIC_N); k++) begin
            send_byte(magic_byte_of(k));
        end
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        // first magic byte twice: the second is not taken as a new start
        send_byte(magic_byte_of(0));
        send_byte(magic_byte_of(0));
        // longest held prefix broken at the last byte
        for (int k = 0; k < int'(MAGIC_N) - 1; k++) begin
            send_byte(magic_byte_of(k));
        end
        send_byte(magic_byte_of(0));
        // resync drops a held prefix
        send_byte(magic_byte_of(0));
        send_byte(magic_byte_of(1));
        send_req(OP_RESYNC, 8'hFF);
        send_byte(magic_byte_of(2));

        run_mixed_traffic(RUN_ITEMS, 1'b0, 1'b0);
        write_magic('0);
        run_mixed_traffic(RUN_ITEMS, 1'b0, 1'b1);
        write_magic('1);
        run_mixed_traffic(RUN_ITEMS, 1'b1, 1'b0);
        write_magic(48'h414141414141);
        run_mixed_traffic(RUN_ITEMS, 1'b0, 1'b0);
        r64 = {$urandom(), $urandom()};
        write_magic(r64[WORD_W-1:0]);
        run_mixed_traffic(RUN_ITEMS, 1'b0, 1'b0);
        write_magic(MAGIC_RESET);
        run_mixed_traffic(RUN_ITEMS, 1'b0, 1'b0);

        $display("%0d requests under %0d magic words, %0d results checked",
                 sent, settings, result_count);
        $display("console bytes, full and aborted frames, broken prefixes, resyncs, long stall");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
